[hw/rtl/quadrature_decoder_velocity_defines.svh]
// Assertion macros for the RTL; empty for synthesis.
`ifndef QUADRATURE_DECODER_VELOCITY_DEFINES_SVH
`define QUADRATURE_DECODER_VELOCITY_DEFINES_SVH

`ifndef SYNTHESIS
`define QDV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qdv assertion failed");
`define QDV_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("qdv reset assertion failed");
`else
`define QDV_ASSERT(lbl, prop)
`define QDV_ASSERT_RST(lbl, prop)
`endif

`endif

[hw/rtl/qdv_pkg.sv]
`timescale 1ns / 1ps
package qdv_pkg;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int OUT_W   = 48;
  localparam int CONST_W = 36;
  localparam int DIV_W   = 50;
  localparam int PROD_W  = OUT_W + CONST_W;
  localparam int CPR_W   = 18;
  localparam int DT_W    = 35;

  localparam logic [CONST_W-1:0] TWO_PI_Q32 = 36'd26986075409;
  localparam logic [CONST_W-1:0] RATE_SCALE = 36'd65536000000;
  localparam logic [TIME_W-1:0]  TS_MAX     = 32'd500000;
  localparam logic [TIME_W-1:0]  TS_DEFAULT = 32'd1000;
  localparam logic [TIME_W-1:0]  TH_STALE   = 32'd100000;

  localparam logic [1:0] CMD_A    = 2'd0;
  localparam logic [1:0] CMD_B    = 2'd1;
  localparam logic [1:0] CMD_VEL  = 2'd2;
  localparam logic [1:0] CMD_ZERO = 2'd3;

  localparam logic REG_PPR  = 1'b0;
  localparam logic REG_QUAD = 1'b1;

  typedef struct packed {
    logic               start;
    logic               rate_c;  // 1: scale by 2^16 * 1e6, 0: by 2*pi * 2^32
    logic               neg;
    logic [OUT_W-1:0]   a;
    logic [DIV_W-1:0]   d;
  } md_req_t;

endpackage

[hw/rtl/qdv_if.sv]
`timescale 1ns / 1ps
interface qdv_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic                         level;
  logic [qdv_pkg::TIME_W-1:0]   time_us;

  modport source (output valid, cmd, level, time_us, input ready);
  modport sink   (input valid, cmd, level, time_us, output ready);
endinterface

interface qdv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qdv_pkg::COUNT_W-1:0]  position_count;
  logic signed [qdv_pkg::OUT_W-1:0]    angle_rad_q16;
  logic signed [qdv_pkg::OUT_W-1:0]    velocity_rad_q16;

  modport source (output valid, position_count, angle_rad_q16, velocity_rad_q16,
                  input ready);
  modport sink   (input valid, position_count, angle_rad_q16, velocity_rad_q16,
                  output ready);
endinterface

[hw/rtl/qdv_muldiv.sv]
`timescale 1ns / 1ps
// Bit-serial a*c/d: MSB-first shift-add multiply, then restoring division,
// one bit per cycle. Result saturated and signed.
module qdv_muldiv (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qdv_pkg::md_req_t        req_i,
  output logic                    done_o,
  output logic [qdv_pkg::OUT_W-1:0] res_o
);
  import qdv_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]         ph_q, ph_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [OUT_W-1:0]   a_q;
  logic [CONST_W-1:0] c_q;
  logic [DIV_W-1:0]   d_q;
  logic               neg_q;
  logic [PROD_W-1:0]  p_q;
  logic [DIV_W-1:0]   rem_q;

  logic [DIV_W:0]     remsh, remsub;
  logic               ge;
  logic [OUT_W-1:0]   sat, mag;

  assign remsh  = {rem_q, p_q[PROD_W-1]};
  assign ge     = remsh >= {1'b0, d_q};
  assign remsub = remsh - {1'b0, d_q};

  always_comb begin
    ph_d  = ph_q;
    cnt_d = cnt_q;
    case (ph_q)
      PH_IDLE: begin
        if (req_i.start) begin
          ph_d  = PH_MUL;
          cnt_d = 7'(CONST_W - 1);
        end
      end
      PH_MUL: begin
        if (cnt_q == '0) begin
          ph_d  = PH_DIV;
          cnt_d = 7'(PROD_W - 1);
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      PH_DIV: begin
        if (cnt_q == '0) ph_d = PH_FIN;
        else cnt_d = cnt_q - 7'd1;
      end
      PH_FIN:  ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      cnt_q <= '0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        if (req_i.start) begin
          a_q   <= req_i.a;
          c_q   <= req_i.rate_c ? RATE_SCALE : TWO_PI_Q32;
          d_q   <= req_i.d;
          neg_q <= req_i.neg;
          p_q   <= '0;
          rem_q <= '0;
        end
      end
      PH_MUL: begin
        p_q <= {p_q[PROD_W-2:0], 1'b0}
               + (c_q[CONST_W-1] ? {{CONST_W{1'b0}}, a_q} : '0);
        c_q <= {c_q[CONST_W-2:0], 1'b0};
      end
      PH_DIV: begin
        rem_q <= ge ? remsub[DIV_W-1:0] : remsh[DIV_W-1:0];
        p_q   <= {p_q[PROD_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign sat    = neg_q ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  assign mag    = (p_q > {{CONST_W{1'b0}}, sat}) ? sat : p_q[OUT_W-1:0];
  assign res_o  = neg_q ? (~mag + 48'd1) : mag;
  assign done_o = (ph_q == PH_FIN);

endmodule

[hw/rtl/quadrature_decoder_velocity.sv]
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_if    in   cmd[1:0], level, time_us[31:0]
// out_if   out  position_count[31:0], angle_rad_q16[47:0], velocity_rad_q16[47:0]
// apb      in   pulses_per_rev @0x0, quadrature_on @0x4
//
// One item at a time: an update state, then one shared bit-serial muldiv
// (shift-add multiply, then restoring divide) for the rate (velocity samples
// only), the angle and the velocity.
// Output register frees the core once the result is loaded; a stalled sink
// holds the next result in the core until the register empties.
// Reset is asynchronous, active low; no clearing pass.
`include "quadrature_decoder_velocity_defines.svh"
module quadrature_decoder_velocity (
  input  logic            clk_i,
  input  logic            rst_ni,
  qdv_in_if.sink          in_if,
  qdv_out_if.source       out_if,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import qdv_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UPD     = 4'd1;
  localparam logic [3:0] S_RATE_GO = 4'd2;
  localparam logic [3:0] S_RATE_WT = 4'd3;
  localparam logic [3:0] S_ANG_GO  = 4'd4;
  localparam logic [3:0] S_ANG_WT  = 4'd5;
  localparam logic [3:0] S_VEL_GO  = 4'd6;
  localparam logic [3:0] S_VEL_WT  = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [15:0]        ppr_q;
  logic               quad_q;

  logic [1:0]         cmd_q;
  logic               lvl_q;
  logic [TIME_W-1:0]  t_q;

  logic               lvl_a_q, lvl_b_q;
  logic [COUNT_W-1:0] cnt_q, cals_q;
  logic [TIME_W-1:0]  let_q, lst_q, lse_q;
  logic [OUT_W-1:0]   rate_q, ang_q, vel_q;
  logic               ang_neg_q, dn_neg_q, rate_go_q;
  logic [COUNT_W-1:0] ang_mag_q, dn_mag_q;
  logic [DT_W-1:0]    dt_q;

  logic               out_valid_q;
  logic [COUNT_W-1:0] out_pos_q;
  logic [OUT_W-1:0]   out_ang_q, out_vel_q;

  // update-cycle logic
  logic [COUNT_W-1:0] cnt_new, dn;
  logic [TIME_W-1:0]  ts_raw, ts, th;
  logic               edge_ev, old_neg, new_neg;
  logic [COUNT_W-1:0] old_mag, new_mag;
  logic [DT_W-1:0]    dt;
  logic               rate_go;

  logic [CPR_W-1:0]   cpr;
  logic [15:0]        ppr_eff;
  logic               vneg;
  logic [OUT_W-1:0]   vmag;
  md_req_t            md_req;
  logic               md_done;
  logic [OUT_W-1:0]   md_res;
  logic               in_acc, out_load;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUAD) ? {31'b0, quad_q} : {16'b0, ppr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q  <= 16'd1024;
      quad_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PPR) ppr_q <= pwdata[15:0];
      else quad_q <= pwdata[0];
    end
  end

  assign ppr_eff = (ppr_q == '0) ? 16'd1 : ppr_q;
  assign cpr     = quad_q ? {ppr_eff, 2'b00} : {2'b00, ppr_eff};

  // item update
  assign old_neg = cnt_q[COUNT_W-1];
  assign old_mag = old_neg ? (~cnt_q + 32'd1) : cnt_q;

  always_comb begin
    cnt_new = cnt_q;
    edge_ev = 1'b0;
    case (cmd_q)
      CMD_A: begin
        edge_ev = (lvl_q != lvl_a_q);
        if (edge_ev) cnt_new = (lvl_a_q == lvl_b_q) ? cnt_q + 32'd1 : cnt_q - 32'd1;
      end
      CMD_B: begin
        edge_ev = (lvl_q != lvl_b_q);
        if (edge_ev) cnt_new = (lvl_a_q != lvl_b_q) ? cnt_q + 32'd1 : cnt_q - 32'd1;
      end
      CMD_ZERO: cnt_new = '0;
      default:  cnt_new = cnt_q;
    endcase
  end

  assign new_neg = cnt_new[COUNT_W-1];
  assign new_mag = new_neg ? (~cnt_new + 32'd1) : cnt_new;

  assign ts_raw  = t_q - lst_q;
  assign ts      = (ts_raw == '0 || ts_raw > TS_MAX) ? TS_DEFAULT : ts_raw;
  assign th      = t_q - let_q;
  assign dn      = cnt_q - cals_q;
  assign dt      = {3'b0, ts} + {3'b0, lse_q} - {3'b0, th};
  // 2*dt > ts also implies dt > 0
  assign rate_go = (th <= TH_STALE) && (dn != '0) && !dt[DT_W-1]
                   && ({dt[DT_W-2:0], 1'b0} > {3'b0, ts});

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_acc) state_d = S_UPD;
      S_UPD:     state_d = (cmd_q == CMD_VEL && rate_go) ? S_RATE_GO : S_ANG_GO;
      S_RATE_GO: state_d = S_RATE_WT;
      S_RATE_WT: if (md_done) state_d = S_ANG_GO;
      S_ANG_GO:  state_d = S_ANG_WT;
      S_ANG_WT:  if (md_done) state_d = S_VEL_GO;
      S_VEL_GO:  state_d = S_VEL_WT;
      S_VEL_WT:  if (md_done) state_d = S_OUT;
      S_OUT:     if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  assign vneg = rate_q[OUT_W-1];
  assign vmag = vneg ? (~rate_q + 48'd1) : rate_q;

  always_comb begin
    md_req = '0;
    case (state_q)
      S_RATE_GO: begin
        md_req.start  = 1'b1;
        md_req.rate_c = 1'b1;
        md_req.neg    = dn_neg_q;
        md_req.a      = {16'b0, dn_mag_q};
        md_req.d      = {15'b0, dt_q};
      end
      S_ANG_GO: begin
        md_req.start = 1'b1;
        md_req.neg   = ang_neg_q;
        md_req.a     = {16'b0, ang_mag_q};
        md_req.d     = {16'b0, cpr, 16'b0};
      end
      S_VEL_GO: begin
        md_req.start = 1'b1;
        md_req.neg   = vneg;
        md_req.a     = vmag;
        md_req.d     = {cpr, 32'b0};
      end
      default: md_req = '0;
    endcase
  end

  qdv_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .done_o (md_done),
    .res_o  (md_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lvl_a_q     <= 1'b0;
      lvl_b_q     <= 1'b0;
      cnt_q       <= '0;
      let_q       <= '0;
      lst_q       <= '0;
      lse_q       <= '0;
      cals_q      <= '0;
      rate_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
      if (state_q == S_UPD) begin
        cnt_q <= cnt_new;
        if (cmd_q == CMD_A && edge_ev) lvl_a_q <= lvl_q;
        if (cmd_q == CMD_B && edge_ev) lvl_b_q <= lvl_q;
        if (edge_ev || cmd_q == CMD_ZERO) let_q <= t_q;
        if (cmd_q == CMD_VEL) begin
          lst_q  <= t_q;
          lse_q  <= th;
          cals_q <= cnt_q;
          if (th > TH_STALE) rate_q <= '0;
        end
      end
      if (state_q == S_RATE_WT && md_done) rate_q <= md_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_if.cmd;
      lvl_q <= in_if.level;
      t_q   <= in_if.time_us;
    end
    if (state_q == S_UPD) begin
      rate_go_q <= rate_go;
      dn_neg_q  <= dn[COUNT_W-1];
      dn_mag_q  <= dn[COUNT_W-1] ? (~dn + 32'd1) : dn;
      dt_q      <= dt;
      if (cmd_q == CMD_ZERO) begin
        ang_neg_q <= !old_neg && (old_mag != '0);
        ang_mag_q <= old_mag;
      end else begin
        ang_neg_q <= new_neg;
        ang_mag_q <= new_mag;
      end
    end
    if (state_q == S_ANG_WT && md_done) ang_q <= md_res;
    if (state_q == S_VEL_WT && md_done) vel_q <= md_res;
    if (out_load) begin
      out_pos_q <= cnt_q;
      out_ang_q <= ang_q;
      out_vel_q <= vel_q;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.position_count   = out_pos_q;
  assign out_if.angle_rad_q16    = out_ang_q;
  assign out_if.velocity_rad_q16 = out_vel_q;

  `QDV_ASSERT_RST(a_rst_no_out, !rst_ni |-> !out_valid_q)
  `QDV_ASSERT(a_acc_to_upd, in_acc |=> state_q == S_UPD)
  `QDV_ASSERT(a_rate_only_vel, (state_q == S_RATE_GO) |-> (cmd_q == CMD_VEL && rate_go_q))
  `QDV_ASSERT(a_load_valid, out_load |=> out_valid_q)

endmodule
